[rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned REQ_W    = 4;
  localparam int unsigned ST_W     = 2;

  // null link marker: top bit set
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 4'd3;
  localparam logic [REQ_W-1:0] REQ_REM_BACK  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_REM_AT    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_RD_FRONT  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_RD_BACK   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_RD_AT     = 4'd8;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd9;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_INS,
    OP_REM,
    OP_RD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SEEK_RD,
    S_STEP,
    S_WR1,
    S_WR2,
    S_RESP
  } state_t;

  // node memory command: one read and one write per array
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              dat_we;
    logic [SLOT_W-1:0] dat_addr;
    logic [DATA_W-1:0] dat_val;
    logic              nxt_we;
    logic [SLOT_W-1:0] nxt_addr;
    logic [LINK_W-1:0] nxt_val;
    logic              prv_we;
    logic [SLOT_W-1:0] prv_addr;
    logic [LINK_W-1:0] prv_val;
  } mem_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } node_t;

endpackage

[rtl/positional_list_engine_top.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of words kept as a doubly linked list with a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one request (type, 1-based position, data word); out_*
//   returns one result per request: status, data word and entry count.
//   A request is taken when valid is high and stall is low.
//   The block handles one request at a time; in_stall is high while a
//   request is in progress and drops the cycle after its result is loaded.
//   Immediate failures and clear go straight to the result. Reads and
//   removals walk links from the cursor, each link a node memory read
//   then a cursor step; inserts first take a slot, walk, then write the
//   node and hook its neighbours, and skip the walk on an empty list.
//   The next request is taken in the cycle after the result is loaded.
//   The result sits in an output register; a new request is taken while
//   it waits. If the receiver keeps out_stall high, the next result holds
//   in the sequencer and in_stall stays high.
//   Reset empties the list; node memories need no clearing.
// ----------------------------------------------------------------------------
module positional_list_engine_top
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DATA_W-1:0] in_item_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [DATA_W-1:0] out_read_data,
  output logic [CNT_W-1:0]  out_entry_count
);

  mem_cmd_t          mem_cmd;
  node_t             rd_node;
  logic              res_valid;
  logic              res_stall;
  logic [ST_W-1:0]   res_status;
  logic [DATA_W-1:0] res_data;
  logic [CNT_W-1:0]  res_count;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   status_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  count_r;
  logic              load;

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_stall  (in_stall),
    .req_type   (in_req_type),
    .req_pos    (in_position),
    .req_data   (in_item_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_status (res_status),
    .res_data   (res_data),
    .res_count  (res_count),
    .mem_cmd    (mem_cmd),
    .rd_node    (rd_node)
  );

  ple_node_mem u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_node (rd_node)
  );

  // output register
  assign res_stall     = out_valid_r && out_stall;
  assign load          = res_valid && !res_stall;
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res_status;
      data_r   <= res_data;
      count_r  <= res_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_data   = data_r;
  assign out_entry_count = count_r;

  // checks
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with nonzero count");

  a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_data == '0)
    else $error("failed request returned data");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

[rtl/ple_node_mem.sv]
// ----------------------------------------------------------------------------
// ple_node_mem
// Node storage: data word, next link and prev link per slot, registered read.
// ----------------------------------------------------------------------------
module ple_node_mem
  import ple_pkg::*;
(
  input  logic     clk,
  input  mem_cmd_t cmd,
  output node_t    rd_node
);

  logic [DATA_W-1:0] dat_mem [CAPACITY];
  logic [LINK_W-1:0] nxt_mem [CAPACITY];
  logic [LINK_W-1:0] prv_mem [CAPACITY];

  // data, next link and prev link arrays, shared read address
  always_ff @(posedge clk) begin
    if (cmd.dat_we) begin
      dat_mem[cmd.dat_addr] <= cmd.dat_val;
    end
    if (cmd.nxt_we) begin
      nxt_mem[cmd.nxt_addr] <= cmd.nxt_val;
    end
    if (cmd.prv_we) begin
      prv_mem[cmd.prv_addr] <= cmd.prv_val;
    end
    if (cmd.rd_en) begin
      rd_node.data <= dat_mem[cmd.rd_addr];
      rd_node.next <= nxt_mem[cmd.rd_addr];
      rd_node.prev <= prv_mem[cmd.rd_addr];
    end
  end

endmodule

[rtl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: decode, slot allocation, cursor walk and link updates.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [POS_W-1:0]  req_pos,
  input  logic [DATA_W-1:0] req_data,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [ST_W-1:0]   res_status,
  output logic [DATA_W-1:0] res_data,
  output logic [CNT_W-1:0]  res_count,
  output mem_cmd_t          mem_cmd,
  input  node_t             rd_node
);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic [POS_W-1:0]  kins_r, kins_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]  never_r, never_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0]  cpos_r, cpos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0] wnext_r, wnext_nxt;
  logic [LINK_W-1:0] wprev_r, wprev_nxt;
  logic [LINK_W-1:0] a_r, a_nxt;
  logic [LINK_W-1:0] b_r, b_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;

  // free slot stack
  logic [SLOT_W-1:0] fs_mem [CAPACITY];
  logic [SLOT_W-1:0] fs_rd_r;
  logic              fs_we;

  logic              acc;
  logic              dec_resp;
  logic              dec_clear;
  logic [ST_W-1:0]   dec_st;
  op_t               dec_op;
  logic [POS_W-1:0]  dec_k;
  logic              is_full;
  logic              is_empty;
  logic [POS_W-1:0]  cnt_p1;

  assign acc      = req_valid && !req_stall;
  assign req_stall = (state_r != S_IDLE);
  assign is_full  = (count_r >= CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign cnt_p1   = POS_W'(count_r) + POS_W'(1);

  // request decode
  always_comb begin
    dec_resp  = 1'b1;
    dec_clear = 1'b0;
    dec_st    = ST_OK;
    dec_op    = OP_RD;
    dec_k     = POS_W'(1);
    unique case (req_type)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        dec_op = OP_INS;
        dec_k  = (req_type == REQ_INS_FRONT) ? POS_W'(1) : cnt_p1;
        if (is_full) begin
          dec_st = ST_FULL;
        end else begin
          dec_resp = 1'b0;
        end
      end
      REQ_INS_AT: begin
        dec_op = OP_INS;
        dec_k  = req_pos;
        priority if (is_empty) begin
          dec_st = ST_EMPTY;
        end else if (req_pos == '0) begin
          dec_st = ST_RANGE;
        end else if (is_full) begin
          dec_st = ST_FULL;
        end else if (req_pos > cnt_p1) begin
          dec_st = ST_RANGE;
        end else begin
          dec_resp = 1'b0;
        end
      end
      REQ_REM_FRONT, REQ_REM_BACK, REQ_REM_AT,
      REQ_RD_FRONT, REQ_RD_BACK, REQ_RD_AT: begin
        dec_op = (req_type <= REQ_REM_AT) ? OP_REM : OP_RD;
        if (req_type == REQ_REM_FRONT || req_type == REQ_RD_FRONT) begin
          dec_k = POS_W'(1);
        end else if (req_type == REQ_REM_BACK || req_type == REQ_RD_BACK) begin
          dec_k = POS_W'(count_r);
        end else begin
          dec_k = req_pos;
        end
        priority if (is_empty) begin
          dec_st = ST_EMPTY;
        end else if (dec_k == '0 || dec_k > POS_W'(count_r)) begin
          dec_st = ST_RANGE;
        end else begin
          dec_resp = 1'b0;
        end
      end
      REQ_CLEAR: begin
        dec_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (dec_resp) begin
            state_nxt = S_RESP;
          end else if (dec_op == OP_INS) begin
            state_nxt = S_ALLOC;
          end else begin
            state_nxt = S_SEEK_RD;
          end
        end
      end
      S_ALLOC:   state_nxt = is_empty ? S_WR1 : S_SEEK_RD;
      S_SEEK_RD: state_nxt = S_STEP;
      S_STEP: begin
        priority if (cpos_r != k_r) begin
          state_nxt = S_SEEK_RD;
        end else if (op_r == OP_INS) begin
          state_nxt = S_WR1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_WR1:  state_nxt = S_WR2;
      S_WR2:  state_nxt = S_RESP;
      S_RESP: state_nxt = res_stall ? S_RESP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory commands
  always_comb begin
    op_nxt    = op_r;
    k_nxt     = k_r;
    kins_nxt  = kins_r;
    slot_nxt  = slot_r;
    data_nxt  = data_r;
    never_nxt = never_r;
    depth_nxt = depth_r;
    cur_nxt   = cur_r;
    cpos_nxt  = cpos_r;
    count_nxt = count_r;
    wnext_nxt = wnext_r;
    wprev_nxt = wprev_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    st_nxt    = st_r;
    rd_nxt    = rd_r;
    fs_we     = 1'b0;
    mem_cmd   = '0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt   = dec_op;
          k_nxt    = dec_k;
          kins_nxt = dec_k;
          data_nxt = req_data;
          st_nxt   = dec_st;
          rd_nxt   = '0;
          if (dec_clear) begin
            never_nxt = '0;
            depth_nxt = '0;
            cur_nxt   = NIL_LINK;
            cpos_nxt  = '0;
            count_nxt = '0;
          end
        end
      end
      S_ALLOC: begin
        // pop a returned slot first, else hand out a fresh one
        if (depth_r != '0) begin
          slot_nxt  = fs_rd_r;
          depth_nxt = depth_r - CNT_W'(1);
        end else begin
          slot_nxt  = never_r[SLOT_W-1:0];
          never_nxt = never_r + CNT_W'(1);
        end
        wnext_nxt = NIL_LINK;
        wprev_nxt = NIL_LINK;
        a_nxt     = NIL_LINK;
        b_nxt     = NIL_LINK;
        k_nxt     = (kins_r <= POS_W'(count_r)) ? kins_r : POS_W'(count_r);
      end
      S_SEEK_RD: begin
        mem_cmd.rd_en   = 1'b1;
        mem_cmd.rd_addr = cur_r[SLOT_W-1:0];
      end
      S_STEP: begin
        priority if (cpos_r < k_r) begin
          cur_nxt  = rd_node.next;
          cpos_nxt = cpos_r + POS_W'(1);
        end else if (cpos_r > k_r) begin
          cur_nxt  = rd_node.prev;
          cpos_nxt = cpos_r - POS_W'(1);
        end else begin
          unique case (op_r)
            OP_INS: begin
              if (kins_r <= POS_W'(count_r)) begin
                wprev_nxt = rd_node.prev;
                wnext_nxt = cur_r;
                a_nxt     = rd_node.prev;
                b_nxt     = cur_r;
              end else begin
                wprev_nxt = cur_r;
                wnext_nxt = NIL_LINK;
                a_nxt     = cur_r;
                b_nxt     = NIL_LINK;
              end
            end
            OP_REM: begin
              // unlink the node and return its slot
              mem_cmd.nxt_we   = !rd_node.prev[LINK_W-1];
              mem_cmd.nxt_addr = rd_node.prev[SLOT_W-1:0];
              mem_cmd.nxt_val  = rd_node.next;
              mem_cmd.prv_we   = !rd_node.next[LINK_W-1];
              mem_cmd.prv_addr = rd_node.next[SLOT_W-1:0];
              mem_cmd.prv_val  = rd_node.prev;
              fs_we            = 1'b1;
              depth_nxt        = depth_r + CNT_W'(1);
              count_nxt        = count_r - CNT_W'(1);
              rd_nxt           = rd_node.data;
              priority if (!rd_node.next[LINK_W-1]) begin
                cur_nxt = rd_node.next;
              end else if (!rd_node.prev[LINK_W-1]) begin
                cur_nxt  = rd_node.prev;
                cpos_nxt = k_r - POS_W'(1);
              end else begin
                cur_nxt  = NIL_LINK;
                cpos_nxt = '0;
              end
            end
            OP_RD: begin
              rd_nxt = rd_node.data;
            end
            default: begin
            end
          endcase
        end
      end
      S_WR1: begin
        mem_cmd.dat_we   = 1'b1;
        mem_cmd.dat_addr = slot_r;
        mem_cmd.dat_val  = data_r;
        mem_cmd.nxt_we   = 1'b1;
        mem_cmd.nxt_addr = slot_r;
        mem_cmd.nxt_val  = wnext_r;
        mem_cmd.prv_we   = 1'b1;
        mem_cmd.prv_addr = slot_r;
        mem_cmd.prv_val  = wprev_r;
      end
      S_WR2: begin
        // hook neighbors to the new slot
        mem_cmd.nxt_we   = !a_r[LINK_W-1];
        mem_cmd.nxt_addr = a_r[SLOT_W-1:0];
        mem_cmd.nxt_val  = {1'b0, slot_r};
        mem_cmd.prv_we   = !b_r[LINK_W-1];
        mem_cmd.prv_addr = b_r[SLOT_W-1:0];
        mem_cmd.prv_val  = {1'b0, slot_r};
        cur_nxt          = {1'b0, slot_r};
        cpos_nxt         = kins_r;
        count_nxt        = count_r + CNT_W'(1);
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_status = st_r;
  assign res_data   = rd_r;
  assign res_count  = count_r;

  // free stack memory
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[depth_r[SLOT_W-1:0]] <= cur_r[SLOT_W-1:0];
    end
    if (acc) begin
      fs_rd_r <= fs_mem[depth_r[SLOT_W-1:0] - SLOT_W'(1)];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      never_r <= '0;
      depth_r <= '0;
      cur_r   <= NIL_LINK;
      cpos_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      never_r <= never_nxt;
      depth_r <= depth_nxt;
      cur_r   <= cur_nxt;
      cpos_r  <= cpos_nxt;
      count_r <= count_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    k_r     <= k_nxt;
    kins_r  <= kins_nxt;
    slot_r  <= slot_nxt;
    data_r  <= data_nxt;
    wnext_r <= wnext_nxt;
    wprev_r <= wprev_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    st_r    <= st_nxt;
    rd_r    <= rd_nxt;
  end

endmodule
